[rtl/fspg_pkg.sv]
// shared types, constants and codes of the fractional step pulse generator
package fspg_pkg;

    localparam int AXES_DEFAULT = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic [31:0] HOME_TRAVEL  = 32'd100000;
    localparam logic [31:0] HOME_STEPS   = ~HOME_TRAVEL + 32'd1;
    localparam logic [31:0] VIBRO_REFILL = 32'd200;
    localparam logic [7:0]  HUNDRED      = 8'd100;
    localparam logic [31:0] RESET_PERIOD = 32'd100000;

    localparam logic [7:0]  DIR_INVERT_RESET = 8'd120;
    localparam logic [7:0]  VIBRO_MASK_RESET = 8'd248;
    localparam logic [63:0] VIBRO_AMPL_RESET = 64'd2165966503140069135;
    localparam logic [15:0] BACKOFF_RESET    = 16'd80;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_MOVE       = 3'd1,
        OP_GOTO       = 3'd2,
        OP_SET_POS    = 3'd3,
        OP_SET_DIV    = 3'd4,
        OP_HOME_START = 3'd5,
        OP_HOME_CHECK = 3'd6
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIR_INVERT = 2'd0,
        CFG_VIBRO_MASK = 2'd1,
        CFG_VIBRO_AMPL = 2'd2,
        CFG_BACKOFF    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [2:0]         axis;
        logic signed [31:0] value;
        logic [6:0]         frac;
        logic               endstop;
    } in_req_t;

    typedef struct packed {
        logic               step_out;
        logic               dir_out;
        logic signed [31:0] position;
        logic signed [31:0] steps_left;
        logic               homing;
        logic               homed;
    } result_t;

    typedef struct packed {
        logic [7:0]  dir_invert_mask;
        logic [7:0]  vibro_mask;
        logic [63:0] vibro_amplitudes;
        logic [15:0] backoff_steps;
    } cfg_t;

    // one memory word per axis
    typedef struct packed {
        logic        pulse_high;
        logic [31:0] remaining;
        logic [31:0] pos_count;
        logic [31:0] tick_count;
        logic [6:0]  hundredth_count;
        logic [31:0] period_int;
        logic [6:0]  period_frac;
        logic [7:0]  vib_count;
        logic        dir_level;
        logic        homing_flag;
        logic        homed_flag;
    } axis_state_t;

    localparam axis_state_t STATE_RESET = '{
        pulse_high:      1'b0,
        remaining:       32'd0,
        pos_count:       32'd0,
        tick_count:      32'd0,
        hundredth_count: 7'd0,
        period_int:      RESET_PERIOD,
        period_frac:     7'd0,
        vib_count:       8'd1,
        dir_level:       1'b1,
        homing_flag:     1'b0,
        homed_flag:      1'b0
    };

endpackage

[rtl/fractional_step_pulse_generator_core.sv]
// top level of the fractional step pulse generator: handshake, config and state update
// a request is held in req_reg while its state word is read; its result is registered
// in the output register once that is free. a new request is taken only once the one in
// flight completes (state memory read on accept, updated and written back on completion)
// reset: synchronous active-low aresetn; config registers take their defaults and the
// per-axis valid bits clear at once, so every axis reads its reset state with no sweep
module fractional_step_pulse_generator_core #(
    parameter int AXES = fspg_pkg::AXES_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fspg_pkg::in_req_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output fspg_pkg::result_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [fspg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fspg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    fspg_pkg::cfg_t        cfg_reg;
    fspg_pkg::cfg_t        cfg_next;
    fspg_pkg::in_req_t     req_reg;
    fspg_pkg::axis_state_t cur_state;
    fspg_pkg::axis_state_t nxt_state;
    fspg_pkg::result_t     upd_res;
    fspg_pkg::result_t     m_data_reg;
    fspg_pkg::result_t     m_data_next;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_range_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  accept;
    logic                  fire;
    logic                  in_range;
    logic                  wr_en;

    assign s_ready  = !s1_valid_reg;
    assign accept   = s_valid && s_ready;
    // the request in flight completes once the output register is free
    assign fire     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign in_range = int'(s_data.axis) < AXES;
    assign wr_en    = fire && s1_range_reg;

    fspg_state_mem #(
        .DEPTH (AXES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (AW'(s_data.axis)),
        .rd_data (cur_state),
        .wr_en   (wr_en),
        .wr_addr (AW'(req_reg.axis)),
        .wr_data (nxt_state)
    );

    fspg_update u_update (
        .req (req_reg),
        .cfg (cfg_reg),
        .cur (cur_state),
        .nxt (nxt_state),
        .res (upd_res)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                fspg_pkg::CFG_DIR_INVERT: cfg_next.dir_invert_mask  = cfg_wdata[7:0];
                fspg_pkg::CFG_VIBRO_MASK: cfg_next.vibro_mask       = cfg_wdata[7:0];
                fspg_pkg::CFG_VIBRO_AMPL: cfg_next.vibro_amplitudes = cfg_wdata;
                fspg_pkg::CFG_BACKOFF:    cfg_next.backoff_steps    = cfg_wdata[15:0];
            endcase
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (fire) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            m_data_next  = s1_range_reg ? upd_res : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dir_invert_mask  <= fspg_pkg::DIR_INVERT_RESET;
            cfg_reg.vibro_mask       <= fspg_pkg::VIBRO_MASK_RESET;
            cfg_reg.vibro_amplitudes <= fspg_pkg::VIBRO_AMPL_RESET;
            cfg_reg.backoff_steps    <= fspg_pkg::BACKOFF_RESET;
            s1_valid_reg             <= 1'b0;
            m_valid_reg              <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg      <= s_data;
            s1_range_reg <= in_range;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_reset_clears : assert property (@(posedge aclk)
        !aresetn |=> !s1_valid_reg && !m_valid_reg)
        else $error("control state not cleared by reset");

    a_accept_loads : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg && !s_ready)
        else $error("accepted request not held for update");

    a_fire_empties : assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> !s1_valid_reg && m_valid_reg)
        else $error("completed request not moved to the output");

    a_out_of_range_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !s1_range_reg |=> m_data_reg == '0 && !$past(wr_en))
        else $error("axis beyond range changed state or gave nonzero result");

endmodule

[rtl/fspg_state_mem.sv]
// per-axis state memory with registered read and per-entry valid bits
module fspg_state_mem #(
    parameter int DEPTH = fspg_pkg::AXES_DEFAULT,
    parameter int AW    = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output fspg_pkg::axis_state_t rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  fspg_pkg::axis_state_t wr_data
);

    fspg_pkg::axis_state_t mem [DEPTH];
    fspg_pkg::axis_state_t rd_word_reg;
    logic [DEPTH-1:0]      valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // an entry never written reads as the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : fspg_pkg::STATE_RESET;

endmodule

[rtl/fspg_update.sv]
// next-state and result logic for one request on one axis
module fspg_update (
    input  fspg_pkg::in_req_t     req,
    input  fspg_pkg::cfg_t        cfg,
    input  fspg_pkg::axis_state_t cur,
    output fspg_pkg::axis_state_t nxt,
    output fspg_pkg::result_t     res
);

    logic [31:0] tick_inc;
    logic [7:0]  hund_inc;
    logic [31:0] rem_step;
    logic [31:0] pos_step;
    logic [7:0]  ampl;
    logic        inv_bit;
    logic        vib_bit;
    logic        move_en;
    logic [31:0] move_steps;

    assign tick_inc = cur.tick_count + 32'd1;
    assign hund_inc = {1'b0, cur.hundredth_count} + 8'd1;
    assign rem_step = cur.remaining[31] ? cur.remaining + 32'd1 : cur.remaining - 32'd1;
    assign pos_step = cur.remaining[31] ? cur.pos_count - 32'd1 : cur.pos_count + 32'd1;
    assign ampl     = cfg.vibro_amplitudes[8*req.axis +: 8];
    assign inv_bit  = cfg.dir_invert_mask[req.axis];
    assign vib_bit  = cfg.vibro_mask[req.axis];

    always_comb begin
        nxt        = cur;
        move_en    = 1'b0;
        move_steps = 32'd0;
        unique case (req.op)
            fspg_pkg::OP_TICK: begin
                nxt.pulse_high = 1'b0;
                if (cur.remaining != 32'd0) begin
                    if ($signed(tick_inc) < $signed(cur.period_int)) begin
                        nxt.tick_count = tick_inc;
                    end else begin
                        // hundredths counter shortens the next period by one
                        nxt.tick_count = (cur.hundredth_count > cur.period_frac) ?
                                         32'd1 : 32'd0;
                        nxt.hundredth_count = (hund_inc >= fspg_pkg::HUNDRED) ?
                                              7'd0 : hund_inc[6:0];
                        nxt.remaining = rem_step;
                        nxt.pos_count = pos_step;
                        if (rem_step != 32'd0) begin
                            nxt.pulse_high = 1'b1;
                            if (vib_bit) begin
                                nxt.remaining = fspg_pkg::VIBRO_REFILL;
                                if (cur.vib_count < ampl) begin
                                    nxt.vib_count = cur.vib_count + 8'd1;
                                end else begin
                                    nxt.vib_count = 8'd0;
                                    nxt.dir_level = ~cur.dir_level;
                                end
                            end
                        end
                    end
                end
            end
            fspg_pkg::OP_MOVE: begin
                move_en    = 1'b1;
                move_steps = req.value;
            end
            fspg_pkg::OP_GOTO: begin
                move_en    = 1'b1;
                move_steps = req.value - cur.pos_count;
            end
            fspg_pkg::OP_SET_POS: begin
                nxt.pos_count = req.value;
            end
            fspg_pkg::OP_SET_DIV: begin
                nxt.period_int  = req.value;
                nxt.period_frac = req.frac;
            end
            fspg_pkg::OP_HOME_START: begin
                nxt.homing_flag = 1'b1;
                move_en         = 1'b1;
                move_steps      = fspg_pkg::HOME_STEPS;
            end
            fspg_pkg::OP_HOME_CHECK: begin
                if (cur.homing_flag && !req.endstop) begin
                    nxt.homing_flag = 1'b0;
                    nxt.homed_flag  = 1'b1;
                    nxt.pos_count   = 32'd0;
                    move_en         = 1'b1;
                    move_steps      = {16'd0, cfg.backoff_steps};
                end
            end
            default: begin
            end
        endcase
        if (move_en) begin
            // a zero move clears the steps and keeps the direction
            if (move_steps == 32'd0) begin
                nxt.remaining = 32'd0;
            end else begin
                nxt.remaining = move_steps;
                nxt.dir_level = ~move_steps[31] ^ inv_bit;
            end
        end
    end

    always_comb begin
        res.step_out   = nxt.pulse_high;
        res.dir_out    = nxt.dir_level;
        res.position   = $signed(nxt.pos_count);
        res.steps_left = $signed(nxt.remaining);
        res.homing     = nxt.homing_flag;
        res.homed      = nxt.homed_flag;
    end

endmodule
